// ----- design/lenient_utf8_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// lenient utf-8 decoder assertion macros
// concurrent assertion wrappers on i_clk, with and without reset masking
// ----------------------------------------------------------------------------
`ifndef LENIENT_UTF8_DECODER_ASSERT_SVH
`define LENIENT_UTF8_DECODER_ASSERT_SVH

// checked only outside reset
`define LUTF8_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LUTF8_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/lutf8_pkg.sv -----
// ----------------------------------------------------------------------------
// lenient utf-8 decoder package
// word types, byte class constants and code point packing functions
// ----------------------------------------------------------------------------
package lutf8_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;

    // sequence length codes
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // byte class masks
    localparam logic [7:0] MSK_TOP   = 8'h80;
    localparam logic [7:0] MSK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2 = 8'hC0;
    localparam logic [7:0] MSK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3 = 8'hE0;
    localparam logic [7:0] MSK_LEAD4 = 8'hF8;
    localparam logic [7:0] PAT_LEAD4 = 8'hF0;

    // result queue
    localparam int unsigned QUE_DEPTH = 4;
    localparam int unsigned QUE_PTR_W = $clog2(QUE_DEPTH);
    localparam int unsigned QUE_CNT_W = $clog2(QUE_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last_of_run;
    } t_out_word;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_NONE;
        if ((b & MSK_LEAD2) == PAT_LEAD2) begin
            len = LEN_2;
        end else if ((b & MSK_LEAD3) == PAT_LEAD3) begin
            len = LEN_3;
        end else if ((b & MSK_LEAD4) == PAT_LEAD4) begin
            len = LEN_4;
        end
        return len;
    endfunction

    function automatic logic is_ascii(input logic [7:0] b);
        return (b & MSK_TOP) == 8'h00;
    endfunction

    function automatic logic [CP_W-1:0] pack2(input logic [7:0] b0, input logic [7:0] b1);
        return {10'd0, b0[4:0], b1[5:0]};
    endfunction

    function automatic logic [CP_W-1:0] pack3(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2);
        return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
    endfunction

    function automatic logic [CP_W-1:0] pack4(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3);
        return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endfunction

endpackage

// ----- design/lutf8_stream_if.sv -----
// ----------------------------------------------------------------------------
// lenient utf-8 decoder stream interface
// valid/ready channel carrying one word of type t_word
// ----------------------------------------------------------------------------
interface lutf8_stream_if #(
    parameter type t_word = logic
) ();
    logic  valid;
    logic  ready;
    t_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- design/lenient_utf8_decoder.sv -----
// ----------------------------------------------------------------------------
// lenient utf-8 decoder
// turns a byte stream into code points, decoding across one pass per byte
// ----------------------------------------------------------------------------
// port     dir  word                            note
// i_byte   in   data_byte[8], end_of_text[1]    one text byte
// o_cp     out  code_point[21], last_of_run[1]  zero to two per byte
//
// one byte per cycle while i_byte.ready is high; decode is one combinational pass into a 4-word queue
// a byte at end of text may give two words, popped from the queue one at a time
// i_byte.ready is high while the queue has room for two words
// i_rst_n is synchronous: drops any open sequence and empties the queue
// ----------------------------------------------------------------------------
`include "lenient_utf8_decoder_assert.svh"

module lenient_utf8_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lutf8_stream_if.sink      i_byte,
    lutf8_stream_if.source    o_cp
);

    // sequence state
    logic [2:0]                          r_slen, n_slen;
    logic [1:0]                          r_hcnt, n_hcnt;
    logic [7:0]                          r_h0, r_h1, r_h2;
    logic [7:0]                          n_h0, n_h1, n_h2;

    // result queue
    lutf8_pkg::t_out_word                r_que [lutf8_pkg::QUE_DEPTH];
    logic [lutf8_pkg::QUE_PTR_W-1:0]     r_wr, r_rd;
    logic [lutf8_pkg::QUE_CNT_W-1:0]     r_cnt, n_cnt;

    logic                                w_acc, w_pop, w_eot, w_done;
    logic [7:0]                          w_b;
    logic [1:0]                          w_nres;
    logic [lutf8_pkg::CP_W-1:0]          w_cp0, w_cp1;
    lutf8_pkg::t_out_word                w_res0, w_res1;

    assign w_b   = i_byte.payload.data_byte;
    assign w_eot = i_byte.payload.end_of_text;

    assign i_byte.ready = (r_cnt <= lutf8_pkg::QUE_CNT_W'(lutf8_pkg::QUE_DEPTH - 2));
    assign w_acc        = i_byte.valid && i_byte.ready;

    assign o_cp.valid   = (r_cnt != '0);
    assign o_cp.payload = r_que[r_rd];
    assign w_pop        = o_cp.valid && o_cp.ready;

    assign w_done = (r_slen != lutf8_pkg::LEN_NONE) && (({1'b0, r_hcnt} + 3'd1) == r_slen);

    always_comb begin
        w_nres = 2'd0;
        w_cp0  = '0;
        w_cp1  = '0;
        n_slen = r_slen;
        n_hcnt = r_hcnt;
        n_h0   = r_h0;
        n_h1   = r_h1;
        n_h2   = r_h2;
        if (r_slen == lutf8_pkg::LEN_NONE) begin
            if (lutf8_pkg::is_ascii(w_b)) begin
                w_nres = 2'd1;
                w_cp0  = {13'd0, w_b};
            end else if (lutf8_pkg::lead_len(w_b) != lutf8_pkg::LEN_NONE && !w_eot) begin
                n_h0   = w_b;
                n_hcnt = 2'd1;
                n_slen = lutf8_pkg::lead_len(w_b);
            end
        end else if (w_done) begin
            w_nres = 2'd1;
            unique case (r_slen)
                lutf8_pkg::LEN_2: w_cp0 = lutf8_pkg::pack2(r_h0, w_b);
                lutf8_pkg::LEN_3: w_cp0 = lutf8_pkg::pack3(r_h0, r_h1, w_b);
                default:          w_cp0 = lutf8_pkg::pack4(r_h0, r_h1, r_h2, w_b);
            endcase
            n_slen = lutf8_pkg::LEN_NONE;
            n_hcnt = 2'd0;
        end else if (w_eot) begin
            // lead dropped, redecode the bytes held after it
            if (r_hcnt == 2'd1) begin
                if (lutf8_pkg::is_ascii(w_b)) begin
                    w_nres = 2'd1;
                    w_cp0  = {13'd0, w_b};
                end
            end else if (lutf8_pkg::is_ascii(r_h1)) begin
                w_cp0 = {13'd0, r_h1};
                if (lutf8_pkg::is_ascii(w_b)) begin
                    w_nres = 2'd2;
                    w_cp1  = {13'd0, w_b};
                end else begin
                    w_nres = 2'd1;
                end
            end else if (lutf8_pkg::lead_len(r_h1) == lutf8_pkg::LEN_2) begin
                w_nres = 2'd1;
                w_cp0  = lutf8_pkg::pack2(r_h1, w_b);
            end else if (lutf8_pkg::is_ascii(w_b)) begin
                w_nres = 2'd1;
                w_cp0  = {13'd0, w_b};
            end
        end else begin
            if (r_hcnt == 2'd1) begin
                n_h1 = w_b;
            end else begin
                n_h2 = w_b;
            end
            n_hcnt = r_hcnt + 2'd1;
        end
        if (w_eot) begin
            n_slen = lutf8_pkg::LEN_NONE;
            n_hcnt = 2'd0;
        end
    end

    assign w_res0.code_point  = w_cp0;
    assign w_res0.last_of_run = (w_nres == 2'd1);
    assign w_res1.code_point  = w_cp1;
    assign w_res1.last_of_run = 1'b1;

    always_comb begin
        n_cnt = r_cnt - lutf8_pkg::QUE_CNT_W'(w_pop);
        if (w_acc) begin
            n_cnt = n_cnt + lutf8_pkg::QUE_CNT_W'(w_nres);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slen <= lutf8_pkg::LEN_NONE;
            r_hcnt <= 2'd0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_acc) begin
                r_slen <= n_slen;
                r_hcnt <= n_hcnt;
                r_wr   <= r_wr + lutf8_pkg::QUE_PTR_W'(w_nres);
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_h0 <= n_h0;
            r_h1 <= n_h1;
            r_h2 <= n_h2;
            if (w_nres != 2'd0) begin
                r_que[r_wr] <= w_res0;
            end
            if (w_nres == 2'd2) begin
                r_que[r_wr + 1'b1] <= w_res1;
            end
        end
    end

    `LUTF8_ASSERT(a_idle_no_held,
        r_slen == lutf8_pkg::LEN_NONE |-> r_hcnt == 2'd0,
        "held bytes with no open sequence")
    `LUTF8_ASSERT(a_held_in_range,
        r_slen != lutf8_pkg::LEN_NONE |-> r_hcnt != 2'd0 && ({1'b0, r_hcnt} < r_slen),
        "held count out of range for sequence")
    `LUTF8_ASSERT(a_eot_closes,
        w_acc && w_eot |=> r_slen == lutf8_pkg::LEN_NONE,
        "sequence left open after end of text")
    `LUTF8_ASSERT(a_pair_kept,
        o_cp.valid && !o_cp.payload.last_of_run |-> r_cnt >= 2,
        "first of a pair without its partner queued")
    `LUTF8_ASSERT(a_que_bound,
        r_cnt <= lutf8_pkg::QUE_CNT_W'(lutf8_pkg::QUE_DEPTH),
        "result queue overfilled")
    `LUTF8_ASSERT_ALWAYS(a_rst_empty,
        !i_rst_n |=> r_cnt == '0,
        "result queue not emptied by reset")

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// lenient utf-8 decoder testbench
// drives text bytes through the valid/ready byte channel with random bursts
// and gaps, decodes each accepted byte in a local model of the decoder and
// checks every code point word, field by field, in arrival order. covers
// well-formed sequences, truncated text, stray and invalid bytes, a long
// output hold-off that fills the block, and a full drain pause.
// ----------------------------------------------------------------------------
module tb;

    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int CP_W        = lutf8_pkg::CP_W;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lutf8_stream_if #(.t_word(lutf8_pkg::t_in_word))  byte_if ();
    lutf8_stream_if #(.t_word(lutf8_pkg::t_out_word)) cp_if ();

    lenient_utf8_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_cp    (cp_if)
    );

    always #5 i_clk = ~i_clk;

    // decoder model state
    logic [7:0] lead_buf [3];
    int         lead_cnt;
    logic [2:0] open_len;

    lutf8_pkg::t_out_word pending_cps [$];
    int         fail_count;
    int         stuck_cycles;
    int         hold_left;
    int         stall_mode;
    int         stall_phase;
    int         burst_left;

    function automatic logic [2:0] seq_size(input logic [7:0] b);
        casez (b)
            8'b110?????: return lutf8_pkg::LEN_2;
            8'b1110????: return lutf8_pkg::LEN_3;
            8'b11110???: return lutf8_pkg::LEN_4;
            default:     return lutf8_pkg::LEN_NONE;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] join_bits(input logic [7:0] seq [4],
                                                  input logic [2:0] len);
        logic [CP_W-1:0] cp;
        case (len)
            lutf8_pkg::LEN_2: cp = CP_W'(seq[0][4:0]);
            lutf8_pkg::LEN_3: cp = CP_W'(seq[0][3:0]);
            default:          cp = CP_W'(seq[0][2:0]);
        endcase
        for (int k = 1; k < int'(len); k++) begin
            cp = {cp[CP_W-7:0], seq[k][5:0]};
        end
        return cp;
    endfunction

    function automatic void clear_seq();
        lead_buf = '{default: 8'h00};
        lead_cnt = 0;
        open_len = lutf8_pkg::LEN_NONE;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eot);
        logic [CP_W-1:0]      cps [2];
        logic [7:0]           seq [4];
        logic [7:0]           rest [3];
        logic [2:0]           len;
        int                   n;
        int                   m;
        int                   i;
        lutf8_pkg::t_out_word w;
        n = 0;
        seq = '{default: 8'h00};
        if (open_len == lutf8_pkg::LEN_NONE) begin
            if (!b[7]) begin
                cps[n] = CP_W'(b);
                n++;
            end else begin
                len = seq_size(b);
                if (len != lutf8_pkg::LEN_NONE && !eot) begin
                    lead_buf[0] = b;
                    lead_cnt = 1;
                    open_len = len;
                end
            end
        end else if (lead_cnt + 1 >= int'(open_len)) begin
            for (int k = 0; k < lead_cnt; k++) seq[k] = lead_buf[k];
            seq[lead_cnt] = b;
            cps[n] = join_bits(seq, open_len);
            n++;
            clear_seq();
        end else if (eot) begin
            // lead dropped, the rest decoded again from the start
            m = 0;
            for (int k = 1; k < lead_cnt; k++) begin
                rest[m] = lead_buf[k];
                m++;
            end
            rest[m] = b;
            m++;
            i = 0;
            while (i < m) begin
                len = seq_size(rest[i]);
                if (!rest[i][7]) begin
                    if (n < 2) begin
                        cps[n] = CP_W'(rest[i]);
                        n++;
                    end
                    i++;
                end else if (len != lutf8_pkg::LEN_NONE && i + int'(len) <= m) begin
                    for (int k = 0; k < int'(len); k++) seq[k] = rest[i + k];
                    if (n < 2) begin
                        cps[n] = join_bits(seq, len);
                        n++;
                    end
                    i += int'(len);
                end else begin
                    i++;
                end
            end
            clear_seq();
        end else begin
            lead_buf[lead_cnt] = b;
            lead_cnt++;
        end
        if (eot) clear_seq();
        for (int j = 0; j < n; j++) begin
            w.code_point  = cps[j];
            w.last_of_run = (j == n - 1);
            pending_cps.insert(pending_cps.size(), w);
        end
    endfunction

    // prediction on accepted bytes, checking on accepted words
    always @(posedge i_clk) begin
        lutf8_pkg::t_out_word want;
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                decode_byte(byte_if.payload.data_byte, byte_if.payload.end_of_text);
            end
            if (cp_if.valid && cp_if.ready) begin
                if (pending_cps.size() == 0) begin
                    $error("unexpected word: code_point %h last_of_run %b",
                           cp_if.payload.code_point, cp_if.payload.last_of_run);
                    fail_count++;
                end else begin
                    want = pending_cps.pop_front();
                    if (cp_if.payload.code_point !== want.code_point) begin
                        $error("code_point: expected %h, actual %h",
                               want.code_point, cp_if.payload.code_point);
                        fail_count++;
                    end
                    if (cp_if.payload.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, actual %b",
                               want.last_of_run, cp_if.payload.last_of_run);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with work pending and nothing moving
    always @(posedge i_clk) begin
        if ((byte_if.valid && byte_if.ready) || (cp_if.valid && cp_if.ready) ||
            !(byte_if.valid || pending_cps.size() > 0)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            cp_if.ready = 1'b0;
            hold_left--;
        end else begin
            if (stall_phase == 0) begin
                stall_mode  = $urandom_range(0, 2);
                stall_phase = $urandom_range(20, 80);
            end
            stall_phase--;
            case (stall_mode)
                0:       cp_if.ready = 1'b1;
                1:       cp_if.ready = 1'($urandom_range(0, 1));
                default: cp_if.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                byte_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        byte_if.payload = '{data_byte: b, end_of_text: eot};
        byte_if.valid   = 1'b1;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] lead_byte(input logic [2:0] len);
        case (len)
            lutf8_pkg::LEN_2: return {3'b110, 5'($urandom)};
            lutf8_pkg::LEN_3: return {4'b1110, 4'($urandom)};
            default:          return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    task automatic test_directed();
        // ascii extremes, one of each length, top code point
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // stray continuation and invalid lead
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // lead byte at end of text
        send_byte(8'hC3, 1'b1);
        // text ends inside a sequence
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        // continuation top bits not checked
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    task automatic test_random_text(input int target);
        logic [7:0] bytes_q [$];
        logic [2:0] len;
        logic       last;
        int         sent;
        int         kind;
        int         k;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 99);
            last = ($urandom_range(0, 11) == 0);
            bytes_q.delete();
            if (kind < 35) begin
                bytes_q.insert(bytes_q.size(), {1'b0, 7'($urandom)});
            end else if (kind < 80) begin
                len = (kind < 55) ? lutf8_pkg::LEN_2 :
                      (kind < 70) ? lutf8_pkg::LEN_3 : lutf8_pkg::LEN_4;
                bytes_q.insert(bytes_q.size(), lead_byte(len));
                for (k = 1; k < int'(len); k++) begin
                    bytes_q.insert(bytes_q.size(),
                                   ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                               : {2'b10, 6'($urandom)});
                end
            end else if (kind < 90) begin
                // text cut short inside a sequence
                len = 3'($urandom_range(2, 4));
                bytes_q.insert(bytes_q.size(), lead_byte(len));
                k = $urandom_range(0, int'(len) - 2);
                repeat (k) begin
                    case ($urandom_range(0, 3))
                        0:       bytes_q.insert(bytes_q.size(), {1'b0, 7'($urandom)});
                        1:       bytes_q.insert(bytes_q.size(), lead_byte(lutf8_pkg::LEN_2));
                        2:       bytes_q.insert(bytes_q.size(), {2'b10, 6'($urandom)});
                        default: bytes_q.insert(bytes_q.size(), 8'($urandom));
                    endcase
                end
                last = 1'b1;
            end else if ($urandom_range(0, 1) == 0) begin
                bytes_q.insert(bytes_q.size(), {2'b10, 6'($urandom)});
            end else begin
                bytes_q.insert(bytes_q.size(), 8'($urandom_range(8'hF8, 8'hFF)));
            end
            for (int j = 0; j < bytes_q.size(); j++) begin
                send_byte(bytes_q[j], last && (j == bytes_q.size() - 1));
            end
            if (kind < 90) sent += bytes_q.size();
        end
    endtask

    task automatic test_drain_pause();
        byte_if.valid = 1'b0;
        while (pending_cps.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_output_hold();
        hold_left = HOLD_CYCLES;
        test_random_text(40);
    endtask

    initial begin
        clear_seq();
        fail_count      = 0;
        stuck_cycles    = 0;
        hold_left       = 0;
        stall_mode      = 0;
        stall_phase     = 0;
        burst_left      = 0;
        i_rst_n         = 1'b0;
        byte_if.valid   = 1'b0;
        byte_if.payload = '0;
        cp_if.ready     = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_drain_pause();
        test_output_hold();
        test_random_text(440);
        test_drain_pause();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/lutf8_pkg.sv
design/lutf8_stream_if.sv
design/lenient_utf8_decoder.sv
sim/tb.sv
